// File: hdl/ccz_pkg.sv
`default_nettype none

package ccz_pkg;

  localparam int unsigned ZoneW = 11;
  localparam int unsigned DeltaW = ZoneW + 1;

  localparam logic [11:0] YearBase = 12'd2000;
  localparam logic [11:0] YearMax = 12'd4095;
  localparam logic [8:0] Cycle400Last = 9'd399;
  localparam logic [8:0] Century1 = 9'd100;
  localparam logic [8:0] Century2 = 9'd200;
  localparam logic [8:0] Century3 = 9'd300;
  localparam logic [7:0] SecPerMin = 8'd60;
  localparam logic [7:0] MinPerHour = 8'd60;
  localparam logic [7:0] HourPerDay = 8'd24;
  localparam logic [7:0] MinLast = 8'd59;
  localparam logic [7:0] HourLast = 8'd23;
  localparam logic [3:0] MonthFirst = 4'd1;
  localparam logic [3:0] MonthLast = 4'd12;
  localparam logic [4:0] DayFirst = 5'd1;
  localparam logic [4:0] DaysLong = 5'd31;
  localparam logic [4:0] DaysFebLeap = 5'd29;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [6:0] MonthMask = 7'h7F;
  localparam logic [DeltaW-1:0] DstMinutes = DeltaW'(60);
  localparam logic [DeltaW-1:0] ZoneBias = DeltaW'(540);

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic {
    CFG_ZONE = 1'b0,
    CFG_DST  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_SEC_FWD  = 2'd0,
    OP_MIN_FWD  = 2'd1,
    OP_MIN_BACK = 2'd2
  } step_op_e;

  typedef struct packed {
    logic       action;
    logic [7:0] bcd_year;
    logic [7:0] bcd_month;
    logic [7:0] bcd_day;
    logic [7:0] bcd_hour;
    logic [7:0] bcd_minute;
    logic [7:0] bcd_second;
    logic [7:0] advance_seconds;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic [7:0]  hour_now;
    logic [7:0]  minute_now;
    logic [7:0]  second_now;
  } out_beat_t;

  // cyc400 tracks year mod 400 for the leap rule
  typedef struct packed {
    logic [11:0] year;
    logic [8:0]  cyc400;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } clock_t;

  function automatic logic [7:0] bcd_value(logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, b[7:4]};
    lo = {4'b0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  function automatic logic [4:0] days_in_month(logic [8:0] cyc400, logic [3:0] month);
    logic is_leap;
    logic [3:0] idx;
    is_leap = (cyc400 == '0) ||
              ((cyc400[1:0] == 2'b00) && (cyc400 != Century1) &&
               (cyc400 != Century2) && (cyc400 != Century3));
    idx = month - MonthFirst;
    if (month < MonthFirst || month > MonthLast) begin
      return DaysLong;
    end
    if (month == MonthFeb && is_leap) begin
      return DaysFebLeap;
    end
    return MonthLen[idx];
  endfunction

endpackage

`default_nettype wire

// File: hdl/calendar_clock_with_zone_shift_core.sv
// Load beat: the clock is stepped by |offset + 60*dst - 540| minutes and the result registered
// (one clock step per cycle through the shared step unit).
// Advance beat: the clock is stepped by advance_seconds seconds and the result registered.
// One beat in flight; the next beat is taken once the result is in the output register.
// Reset: clock 2000-01-01 00:00:00, zone offset and daylight flag zero, no result pending.
`default_nettype none

module calendar_clock_with_zone_shift_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire                        cfg_idx_i,
  input  wire [ccz_pkg::ZoneW-1:0]   cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  var ccz_pkg::in_beat_t      in_beat_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output ccz_pkg::out_beat_t         out_beat_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLAMP = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_ADV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  localparam int unsigned DW = ccz_pkg::DeltaW;

  state_e                   state_q, state_d;
  ccz_pkg::clock_t          st_q, st_d, st_step;
  ccz_pkg::step_op_e        step_op;
  logic [ccz_pkg::ZoneW-1:0] zone_q;
  logic                     dst_q;
  logic [DW-1:0]            delta_q, delta_d;
  logic [7:0]               count_q, count_d;
  logic [7:0]               day_raw_q, day_raw_d;
  ccz_pkg::out_beat_t       out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  ccz_step u_step (
    .st_i (st_q),
    .op_i (step_op),
    .st_o (st_step)
  );

  assign step_op = (state_q == ST_SHIFT) ?
                   (delta_q[DW-1] ? ccz_pkg::OP_MIN_BACK : ccz_pkg::OP_MIN_FWD) :
                   ccz_pkg::OP_SEC_FWD;

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_q;

  always_comb begin
    logic [7:0] yv;
    logic [7:0] mv;
    logic [4:0] dim;

    state_d = state_q;
    st_d = st_q;
    delta_d = delta_q;
    count_d = count_q;
    day_raw_d = day_raw_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    yv = ccz_pkg::bcd_value(in_beat_i.bcd_year);
    mv = ccz_pkg::bcd_value({1'b0, in_beat_i.bcd_month[6:0] & ccz_pkg::MonthMask});
    dim = ccz_pkg::days_in_month(st_q.cyc400, st_q.month);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_beat_i.action) begin
            count_d = in_beat_i.advance_seconds;
            state_d = ST_ADV;
          end else begin
            st_d.year = ccz_pkg::YearBase + {4'b0, yv};
            st_d.cyc400 = {1'b0, yv};
            if (mv == '0) begin
              st_d.month = ccz_pkg::MonthFirst;
            end else if (mv > {4'b0, ccz_pkg::MonthLast}) begin
              st_d.month = ccz_pkg::MonthLast;
            end else begin
              st_d.month = mv[3:0];
            end
            day_raw_d = ccz_pkg::bcd_value(in_beat_i.bcd_day);
            st_d.hour = ccz_pkg::bcd_value(in_beat_i.bcd_hour);
            st_d.minute = ccz_pkg::bcd_value(in_beat_i.bcd_minute);
            st_d.second = ccz_pkg::bcd_value(in_beat_i.bcd_second);
            delta_d = {zone_q[ccz_pkg::ZoneW-1], zone_q} +
                      (dst_q ? ccz_pkg::DstMinutes : '0) - ccz_pkg::ZoneBias;
            state_d = ST_CLAMP;
          end
        end
      end
      ST_CLAMP: begin
        if (day_raw_q == '0) begin
          st_d.day = ccz_pkg::DayFirst;
        end else if (day_raw_q > {3'b0, dim}) begin
          st_d.day = dim;
        end else begin
          st_d.day = day_raw_q[4:0];
        end
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (delta_q == '0) begin
          state_d = ST_DONE;
        end else begin
          st_d = st_step;
          delta_d = delta_q[DW-1] ? delta_q + DW'(1) : delta_q - DW'(1);
        end
      end
      ST_ADV: begin
        if (count_q == '0) begin
          state_d = ST_DONE;
        end else begin
          st_d = st_step;
          count_d = count_q - 8'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.year_now = st_q.year;
          out_d.month_now = st_q.month;
          out_d.day_now = st_q.day;
          out_d.hour_now = st_q.hour;
          out_d.minute_now = st_q.minute;
          out_d.second_now = st_q.second;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      st_q.year <= ccz_pkg::YearBase;
      st_q.cyc400 <= '0;
      st_q.month <= ccz_pkg::MonthFirst;
      st_q.day <= ccz_pkg::DayFirst;
      st_q.hour <= '0;
      st_q.minute <= '0;
      st_q.second <= '0;
      zone_q <= '0;
      dst_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ccz_pkg::CFG_ZONE: zone_q <= cfg_wdata_i;
          ccz_pkg::CFG_DST:  dst_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    count_q <= count_d;
    day_raw_q <= day_raw_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// File: hdl/ccz_step.sv
`default_nettype none

module ccz_step (
  input  var ccz_pkg::clock_t   st_i,
  input  var ccz_pkg::step_op_e op_i,
  output ccz_pkg::clock_t       st_o
);

  always_comb begin
    logic       carry_min;
    logic [7:0] sec_inc;
    logic [7:0] min_inc;
    logic [7:0] hour_inc;
    logic [4:0] day_inc;
    logic [3:0] mon_inc;
    logic [4:0] dim;

    st_o = st_i;
    carry_min = 1'b0;
    sec_inc = st_i.second + 8'd1;
    min_inc = st_i.minute + 8'd1;
    hour_inc = st_i.hour + 8'd1;
    day_inc = st_i.day + 5'd1;
    mon_inc = st_i.month + 4'd1;
    dim = ccz_pkg::days_in_month(st_i.cyc400, st_i.month);

    case (op_i)
      ccz_pkg::OP_SEC_FWD, ccz_pkg::OP_MIN_FWD: begin
        if (op_i == ccz_pkg::OP_MIN_FWD) begin
          carry_min = 1'b1;
        end else if (sec_inc >= ccz_pkg::SecPerMin) begin
          st_o.second = '0;
          carry_min = 1'b1;
        end else begin
          st_o.second = sec_inc;
        end
        if (carry_min) begin
          if (min_inc < ccz_pkg::MinPerHour) begin
            st_o.minute = min_inc;
          end else begin
            st_o.minute = '0;
            if (hour_inc < ccz_pkg::HourPerDay) begin
              st_o.hour = hour_inc;
            end else begin
              st_o.hour = '0;
              if ({1'b0, day_inc} <= {1'b0, dim} && st_i.day != ccz_pkg::DaysLong) begin
                st_o.day = day_inc;
              end else begin
                st_o.day = ccz_pkg::DayFirst;
                if (mon_inc <= ccz_pkg::MonthLast) begin
                  st_o.month = mon_inc;
                end else begin
                  st_o.month = ccz_pkg::MonthFirst;
                  if (st_i.year < ccz_pkg::YearMax) begin
                    st_o.year = st_i.year + 12'd1;
                    st_o.cyc400 = (st_i.cyc400 == ccz_pkg::Cycle400Last) ? '0
                                                                         : st_i.cyc400 + 9'd1;
                  end
                end
              end
            end
          end
        end
      end
      ccz_pkg::OP_MIN_BACK: begin
        if (st_i.minute != '0) begin
          st_o.minute = st_i.minute - 8'd1;
        end else begin
          st_o.minute = ccz_pkg::MinLast;
          if (st_i.hour != '0) begin
            st_o.hour = st_i.hour - 8'd1;
          end else begin
            st_o.hour = ccz_pkg::HourLast;
            if (st_i.day > ccz_pkg::DayFirst) begin
              st_o.day = st_i.day - 5'd1;
            end else begin
              if (st_i.month <= ccz_pkg::MonthFirst) begin
                st_o.month = ccz_pkg::MonthLast;
                if (st_i.year != '0) begin
                  st_o.year = st_i.year - 12'd1;
                  st_o.cyc400 = (st_i.cyc400 == '0) ? ccz_pkg::Cycle400Last
                                                    : st_i.cyc400 - 9'd1;
                end
              end else begin
                st_o.month = st_i.month - 4'd1;
              end
              st_o.day = ccz_pkg::days_in_month(st_o.cyc400, st_o.month);
            end
          end
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ccz_checker.sv
`default_nettype none

module ccz_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_stall_o,
  input wire                       out_valid_o,
  input wire                       out_stall_i,
  input var ccz_pkg::out_beat_t    out_beat_o
);

  // a beat in work holds off the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a beat is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result changed");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.month_now >= ccz_pkg::MonthFirst &&
                    out_beat_o.month_now <= ccz_pkg::MonthLast)
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.day_now >= ccz_pkg::DayFirst)
    else $error("day is zero");

endmodule

bind calendar_clock_with_zone_shift_core ccz_checker u_ccz_checker (.*);

`default_nettype wire

// File: tb/tb_calendar_clock_with_zone_shift_core.sv
`timescale 1ns / 1ps

module tb_calendar_clock_with_zone_shift_core;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned BEATS_PER_PHASE = 54;

  typedef struct {
    bit                  is_cfg;
    ccz_pkg::cfg_idx_e   idx;
    logic [10:0]         wdata;
    ccz_pkg::in_beat_t   beat;
  } feed_entry_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic                       cfg_idx_i;
  logic [ccz_pkg::ZoneW-1:0]  cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  ccz_pkg::in_beat_t          in_beat_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  ccz_pkg::out_beat_t         out_beat_o;

  calendar_clock_with_zone_shift_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  feed_entry_t          feed_q[$];
  ccz_pkg::out_beat_t   due_q[$];

  // predicted clock and register copies
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [7:0]  cal_hour;
  logic [7:0]  cal_min;
  logic [7:0]  cal_sec;
  logic [10:0] zone_raw;
  logic        dst_on;

  logic        beat_taken;
  logic        res_taken;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          send_busy;
  bit          recv_busy;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned results_seen;

  function automatic logic [7:0] bcd_to_bin(logic [7:0] b);
    return 8'(b[7:4] * 10 + b[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned v);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  function automatic bit leap_year(logic [11:0] y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic logic [4:0] month_length(logic [11:0] y, logic [3:0] m);
    case (m)
      4'd2: return leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic void day_up();
    cal_hour = 8'd0;
    if (cal_day < month_length(cal_year, cal_month)) begin
      cal_day = cal_day + 5'd1;
      return;
    end
    cal_day = 5'd1;
    if (cal_month < 4'd12) begin
      cal_month = cal_month + 4'd1;
      return;
    end
    cal_month = 4'd1;
    if (cal_year < 12'd4095) cal_year = cal_year + 12'd1;
  endfunction

  function automatic void minute_up();
    cal_min = cal_min + 8'd1;
    if (cal_min < 8'd60) return;
    cal_min = 8'd0;
    cal_hour = cal_hour + 8'd1;
    if (cal_hour < 8'd24) return;
    day_up();
  endfunction

  function automatic void second_up();
    cal_sec = cal_sec + 8'd1;
    if (cal_sec < 8'd60) return;
    cal_sec = 8'd0;
    minute_up();
  endfunction

  function automatic void minute_down();
    if (cal_min != 8'd0) begin
      cal_min = cal_min - 8'd1;
      return;
    end
    cal_min = 8'd59;
    if (cal_hour != 8'd0) begin
      cal_hour = cal_hour - 8'd1;
      return;
    end
    cal_hour = 8'd23;
    if (cal_day > 5'd1) begin
      cal_day = cal_day - 5'd1;
      return;
    end
    if (cal_month <= 4'd1) begin
      cal_month = 4'd12;
      if (cal_year != 12'd0) cal_year = cal_year - 12'd1;
    end else begin
      cal_month = cal_month - 4'd1;
    end
    cal_day = month_length(cal_year, cal_month);
  endfunction

  function automatic ccz_pkg::out_beat_t predict_clock(ccz_pkg::in_beat_t b);
    int                 shift;
    logic [7:0]         mon;
    logic [7:0]         dom;
    ccz_pkg::out_beat_t r;
    if (b.action == ACT_LOAD) begin
      cal_year = 12'd2000 + 12'(bcd_to_bin(b.bcd_year));
      mon = bcd_to_bin(b.bcd_month & 8'h7F);
      dom = bcd_to_bin(b.bcd_day);
      cal_hour = bcd_to_bin(b.bcd_hour);
      cal_min = bcd_to_bin(b.bcd_minute);
      cal_sec = bcd_to_bin(b.bcd_second);
      if (mon < 8'd1) mon = 8'd1;
      if (mon > 8'd12) mon = 8'd12;
      cal_month = mon[3:0];
      if (dom < 8'd1) dom = 8'd1;
      if (dom > {3'b0, month_length(cal_year, cal_month)}) begin
        dom = {3'b0, month_length(cal_year, cal_month)};
      end
      cal_day = dom[4:0];
      shift = int'($signed(zone_raw)) + (dst_on ? 60 : 0) - 540;
      while (shift > 0) begin
        minute_up();
        shift--;
      end
      while (shift < 0) begin
        minute_down();
        shift++;
      end
    end else begin
      repeat (b.advance_seconds) second_up();
    end
    r.year_now = cal_year;
    r.month_now = cal_month;
    r.day_now = cal_day;
    r.hour_now = cal_hour;
    r.minute_now = cal_min;
    r.second_now = cal_sec;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch on result %0d: %s got %0d, expected %0d",
             results_seen, what, got, want);
  endtask

  function automatic ccz_pkg::in_beat_t load_beat(logic [7:0] y, logic [7:0] mo,
                                                  logic [7:0] d, logic [7:0] h,
                                                  logic [7:0] mi, logic [7:0] s);
    ccz_pkg::in_beat_t b;
    b.action = ACT_LOAD;
    b.bcd_year = y;
    b.bcd_month = mo;
    b.bcd_day = d;
    b.bcd_hour = h;
    b.bcd_minute = mi;
    b.bcd_second = s;
    b.advance_seconds = 8'($urandom);
    return b;
  endfunction

  function automatic ccz_pkg::in_beat_t advance_beat(logic [7:0] n);
    ccz_pkg::in_beat_t b;
    b = ccz_pkg::in_beat_t'({$urandom, $urandom});
    b.action = ACT_ADVANCE;
    b.advance_seconds = n;
    return b;
  endfunction

  function automatic ccz_pkg::in_beat_t random_beat();
    ccz_pkg::in_beat_t b;
    if ($urandom_range(0, 4) == 0) begin
      b = ccz_pkg::in_beat_t'({$urandom, $urandom});
    end else if ($urandom_range(0, 2) == 0) begin
      // near a month or day boundary
      b = load_beat(to_bcd($urandom_range(0, 99)), to_bcd($urandom_range(1, 12)),
                    to_bcd($urandom_range(27, 31)), to_bcd($urandom_range(20, 23)),
                    to_bcd($urandom_range(50, 59)), to_bcd($urandom_range(0, 59)));
    end else begin
      b = load_beat(to_bcd($urandom_range(0, 99)), to_bcd($urandom_range(1, 12)),
                    to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(0, 23)),
                    to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)));
    end
    if ($urandom_range(0, 1) == 1) begin
      b.action = ACT_ADVANCE;
    end
    b.advance_seconds = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic push_beat(ccz_pkg::in_beat_t b);
    feed_entry_t e;
    e.is_cfg = 1'b0;
    e.idx = ccz_pkg::CFG_ZONE;
    e.wdata = '0;
    e.beat = b;
    feed_q.push_back(e);
  endtask

  task automatic push_cfg(ccz_pkg::cfg_idx_e idx, logic [10:0] v);
    feed_entry_t e;
    e.is_cfg = 1'b1;
    e.idx = idx;
    e.wdata = v;
    e.beat = '0;
    feed_q.push_back(e);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin : drive_in
    logic        send;
    logic        we;
    feed_entry_t head;
    if (rst_ni) begin
      send = in_valid_i && !beat_taken;
      we = 1'b0;
      if (!send) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (feed_q.size() != 0) begin
          head = feed_q[0];
          if (head.is_cfg) begin
            // registers change only with nothing in flight
            if (due_q.size() == 0) begin
              we = 1'b1;
              cfg_idx_i <= head.idx;
              cfg_wdata_i <= head.wdata;
              if (head.idx == ccz_pkg::CFG_ZONE) zone_raw = head.wdata;
              else dst_on = head.wdata[0];
              feed_q.delete(0);
            end
          end else begin
            send = 1'b1;
            in_beat_i <= head.beat;
            feed_q.delete(0);
            if ($urandom_range(0, 15) == 0) send_busy = !send_busy;
            gap_left = send_busy ? $urandom_range(0, 7) : 0;
          end
        end
      end
      in_valid_i <= send;
      cfg_we_i <= we;
    end
  end

  always @(negedge clk_i) begin : drive_out
    if (rst_ni) begin
      if (res_taken) begin
        if ($urandom_range(0, 15) == 0) recv_busy = !recv_busy;
        stall_left = recv_busy ? $urandom_range(0, 7) : 0;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    ccz_pkg::out_beat_t seen;
    ccz_pkg::out_beat_t want;
    if (rst_ni) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        beat_taken <= in_valid_i && !in_stall_o;
        res_taken <= out_valid_o && !out_stall_i;
        if (out_valid_o && !out_stall_i) begin
          seen = out_beat_o;
          results_seen++;
          if (due_q.size() == 0) begin
            report_mismatch("result with nothing due, year", seen.year_now, 0);
          end else begin
            want = due_q.pop_front();
            if (seen.year_now !== want.year_now)
              report_mismatch("year", seen.year_now, want.year_now);
            if (seen.month_now !== want.month_now)
              report_mismatch("month", seen.month_now, want.month_now);
            if (seen.day_now !== want.day_now)
              report_mismatch("day", seen.day_now, want.day_now);
            if (seen.hour_now !== want.hour_now)
              report_mismatch("hour", seen.hour_now, want.hour_now);
            if (seen.minute_now !== want.minute_now)
              report_mismatch("minute", seen.minute_now, want.minute_now);
            if (seen.second_now !== want.second_now)
              report_mismatch("second", seen.second_now, want.second_now);
          end
        end
        if (in_valid_i && !in_stall_o) begin
          due_q.push_back(predict_clock(in_beat_i));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned p;
    logic [10:0] zone_pick;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ccz_pkg::CFG_ZONE;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    out_stall_i = 1'b0;
    beat_taken = 1'b0;
    res_taken = 1'b0;
    gap_left = 0;
    stall_left = 0;
    send_busy = 1'b1;
    recv_busy = 1'b1;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    cal_year = 12'd2000;
    cal_month = 4'd1;
    cal_day = 5'd1;
    cal_hour = 8'd0;
    cal_min = 8'd0;
    cal_sec = 8'd0;
    zone_raw = '0;
    dst_on = 1'b0;

    // no net shift: decode, clamping and advance steps
    push_cfg(ccz_pkg::CFG_ZONE, 11'd540);
    push_cfg(ccz_pkg::CFG_DST, 11'd0);
    push_beat(load_beat(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_beat(load_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_beat(advance_beat(8'd255));
    push_beat(load_beat(8'h00, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00));
    push_beat(load_beat(8'hA0, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00));
    push_beat(load_beat(8'h04, 8'h02, 8'h31, 8'h00, 8'h00, 8'h00));
    push_beat(load_beat(8'h99, 8'h92, 8'h31, 8'h23, 8'h59, 8'h59));
    push_beat(advance_beat(8'd1));
    push_beat(advance_beat(8'd0));
    push_beat(load_beat(8'h23, 8'h04, 8'h31, 8'h00, 8'h00, 8'h00));
    push_beat(advance_beat(8'h80));

    // most negative zone: long backward walk
    push_cfg(ccz_pkg::CFG_ZONE, 11'h400);
    push_beat(load_beat(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
    push_beat(load_beat(8'h00, 8'h03, 8'h01, 8'h00, 8'h10, 8'h00));
    push_beat(load_beat(8'h00, 8'h01, 8'h01, 8'h99, 8'h00, 8'h00));
    push_beat(load_beat(8'h01, 8'h01, 8'h01, 8'h00, 8'hFF, 8'h30));

    // most positive zone with daylight saving: forward walk
    push_cfg(ccz_pkg::CFG_ZONE, 11'h3FF);
    push_cfg(ccz_pkg::CFG_DST, 11'd1);
    push_beat(load_beat(8'h99, 8'h12, 8'h31, 8'h23, 8'h00, 8'h00));
    push_beat(load_beat(8'hFF, 8'h12, 8'h31, 8'h23, 8'h50, 8'h00));
    push_beat(load_beat(8'h00, 8'h02, 8'h28, 8'h20, 8'h00, 8'h00));
    push_beat(load_beat(8'h00, 8'h01, 8'h01, 8'h30, 8'h00, 8'h00));

    push_cfg(ccz_pkg::CFG_ZONE, 11'h7FF);
    push_beat(load_beat(8'h00, 8'h03, 8'h01, 8'h05, 8'h00, 8'h00));
    push_cfg(ccz_pkg::CFG_ZONE, 11'd0);
    push_cfg(ccz_pkg::CFG_DST, 11'd0);
    push_beat(load_beat(8'h12, 8'h01, 8'h01, 8'h03, 8'h00, 8'h00));
    push_beat(advance_beat(8'd255));

    for (p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) zone_pick = 11'h400;
      else if (p == 1) zone_pick = 11'h3FF;
      else zone_pick = 11'($urandom_range(0, 2047));
      push_cfg(ccz_pkg::CFG_ZONE, zone_pick);
      push_cfg(ccz_pkg::CFG_DST, 11'($urandom_range(0, 1)));
      repeat (BEATS_PER_PHASE) push_beat(random_beat());
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (feed_q.size() != 0 || in_valid_i || due_q.size() != 0) @(negedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
